// File: rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared widths, pipeline stage numbers, constants and types for the
// go-to-goal velocity controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

    // fixed point format of positions, gains and commands
    localparam int FRAC_BITS = 12;
    // fraction bits of the sine and cosine unit
    localparam int CQ = 30;

    // field widths
    localparam int POS_W  = 16;
    localparam int HEAD_W = 15;
    localparam int MAG_W  = POS_W;
    localparam int D2_W   = 2 * MAG_W + 1;
    localparam int DIST_W = MAG_W + 1;
    localparam int SPD_W  = 15;
    localparam int NUM_W  = D2_W;
    localparam int DEN_W  = DIST_W + 1;
    localparam int QUO_W  = 16;

    // angle and rotation widths
    localparam int ANG_W  = 35;
    localparam int Z_W    = 33;
    localparam int XY_W   = 34;
    localparam int CS_W   = 32;

    // unit depths
    localparam int SQRT_STEPS  = DIST_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int CORDIC_ITER = 30;
    localparam int CORDIC_LAT  = CORDIC_ITER + 2;

    // pipeline stage numbers, counted in registers after the accept edge
    localparam int ST_D2   = 2;
    localparam int ST_AG   = ST_D2 + 1;
    localparam int ST_DIST = ST_D2 + SQRT_STEPS;
    localparam int ST_SPD  = ST_DIST + 1;
    localparam int ST_NUM  = ST_SPD + 1;
    localparam int ST_Q    = ST_NUM + DIV_STEPS;
    localparam int ST_VEL  = ST_Q + 1;
    localparam int ST_PROD = ST_VEL + 1;
    localparam int ST_SUM  = ST_PROD + 1;
    localparam int ST_TURN = ST_SUM + 1;
    localparam int ST_OUT  = ST_TURN + 1;
    localparam int CS_DLY  = ST_VEL - 1 - CORDIC_LAT;

    // angle constants in Q.30
    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_Q30 [CORDIC_ITER] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043836, 33'sd133525158,
        33'sd67021686, 33'sd33543515, 33'sd16775850, 33'sd8388437,
        33'sd4194282, 33'sd2097149, 33'sd1048575, 33'sd524287,
        33'sd262143, 33'sd131071, 33'sd65535, 33'sd32767, 33'sd16383,
        33'sd8191, 33'sd4095, 33'sd2047, 33'sd1023, 33'sd511, 33'sd255,
        33'sd127, 33'sd63, 33'sd31, 33'sd15, 33'sd7, 33'sd3, 33'sd1
    };

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRN_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd5;

    // per-item flags and offset magnitudes that ride along the pipeline
    typedef struct packed {
        logic             pv;
        logic             ag;
        logic             dz;
        logic             xneg;
        logic             yneg;
        logic [MAG_W-1:0] xmag;
        logic [MAG_W-1:0] ymag;
    } meta_t;

endpackage

// File: rtl/gtg_sqrt.sv
// ----------------------------------------------------------------------------
// gtg_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gtg_sqrt import gtg_pkg::*;
(
    input  logic              clk,
    input  logic [D2_W-1:0]   d2,
    output logic [DIST_W-1:0] root
);

    localparam int RAD_W  = 2 * SQRT_STEPS;
    localparam int SREM_W = DIST_W + 3;

    logic [RAD_W-1:0]  rad_reg  [SQRT_STEPS+1];
    logic [SREM_W-1:0] rem_reg  [SQRT_STEPS+1];
    logic [DIST_W-1:0] root_reg [SQRT_STEPS+1];

    // step zero is the unregistered input
    always_comb
    begin
        rad_reg[0]  = RAD_W'(d2);
        rem_reg[0]  = '0;
        root_reg[0] = '0;
    end

    // one pair of radicand bits per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic [SREM_W-1:0] trial;
        logic [SREM_W-1:0] rem_in;
        logic [SREM_W-1:0] rem_next;
        logic [DIST_W-1:0] root_next;

        always_comb
        begin
            rem_in = {rem_reg[k][SREM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
            trial  = {1'b0, root_reg[k], 2'b01};
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = {root_reg[k][DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_in;
                root_next = {root_reg[k][DIST_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k+1]  <= {rad_reg[k][RAD_W-3:0], 2'b00};
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
        end
    end

    assign root = root_reg[SQRT_STEPS];

endmodule

// File: rtl/gtg_div.sv
// ----------------------------------------------------------------------------
// gtg_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module gtg_div import gtg_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [DIV_STEPS+1];
    logic [QUO_W-1:0] lo_reg  [DIV_STEPS+1];
    logic [DEN_W-1:0] den_reg [DIV_STEPS+1];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS+1];

    // upper numerator bits are already below the divisor
    always_comb
    begin
        rem_reg[0] = DEN_W'(num[NUM_W-1:QUO_W]);
        lo_reg[0]  = num[QUO_W-1:0];
        den_reg[0] = den;
        quo_reg[0] = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem_next;
        logic             qbit;

        always_comb
        begin
            trial = {rem_reg[k], lo_reg[k][QUO_W-1]};
            qbit  = (trial >= {1'b0, den_reg[k]});
            if (qbit)
                rem_next = DEN_W'(trial - {1'b0, den_reg[k]});
            else
                rem_next = trial[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            lo_reg[k+1]  <= {lo_reg[k][QUO_W-2:0], 1'b0};
            den_reg[k+1] <= den_reg[k];
            quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], qbit};
        end
    end

    assign quo = quo_reg[DIV_STEPS];

endmodule

// File: rtl/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic
// Pipelined rotation-mode CORDIC giving cosine and sine in Q.30 of an angle
// already reduced to minus pi to pi.
// ----------------------------------------------------------------------------
module gtg_cordic import gtg_pkg::*;
(
    input  logic                    clk,
    input  logic signed [ANG_W-1:0] ang,
    output logic signed [CS_W-1:0]  cos_q,
    output logic signed [CS_W-1:0]  sin_q
);

    logic signed [XY_W-1:0] x_reg [CORDIC_ITER+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_ITER+1];
    logic signed [Z_W-1:0]  z_reg [CORDIC_ITER+1];
    logic                   neg_reg [CORDIC_ITER+1];

    logic signed [ANG_W-1:0] fold_next;
    logic                    neg_next;
    logic signed [XY_W-1:0]  xneg;
    logic signed [XY_W-1:0]  yneg;

    // fold into minus pi/2 to pi/2 with a half turn
    always_comb
    begin
        neg_next  = 1'b0;
        fold_next = ang;
        if (ang > HALF_PI_Q30)
        begin
            fold_next = ang - PI_Q30;
            neg_next  = 1'b1;
        end
        else if (ang < -HALF_PI_Q30)
        begin
            fold_next = ang + PI_Q30;
            neg_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= GAIN_Q30;
        y_reg[0]   <= '0;
        z_reg[0]   <= fold_next[Z_W-1:0];
        neg_reg[0] <= neg_next;
    end

    // micro-rotations
    for (genvar i = 0; i < CORDIC_ITER; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN_Q30[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN_Q30[i];
            end
            neg_reg[i+1] <= neg_reg[i];
        end
    end

    // undo the half turn
    assign xneg = -x_reg[CORDIC_ITER];
    assign yneg = -y_reg[CORDIC_ITER];

    always_ff @(posedge clk)
    begin
        if (neg_reg[CORDIC_ITER])
        begin
            cos_q <= xneg[CS_W-1:0];
            sin_q <= yneg[CS_W-1:0];
        end
        else
        begin
            cos_q <= x_reg[CORDIC_ITER][CS_W-1:0];
            sin_q <= y_reg[CORDIC_ITER][CS_W-1:0];
        end
    end

endmodule

// File: rtl/go_to_goal_velocity_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller
// Proportional go-to-goal controller giving forward and turn commands for a
// differential-drive robot from one pose sample and a goal point.
//
// Usage:
//   An item (pose_valid, pos_x, pos_y, heading, target_x, target_y) is taken
//   at each rising edge where start is high and busy is low. busy is always
//   low, so a new item may be given every cycle.
//   The result (forward_velocity, turn_rate, at_goal) is registered and is
//   shown for one cycle with done high. Results come out in the order the
//   items went in, one per cycle at most. The pipeline depth is set by the
//   17-stage square root and the 16-stage divider in series; the 32-stage
//   CORDIC for the heading runs beside them. Throughput is one item per clock.
//   The receiver cannot stall; done must be sampled when it is high.
//   Registers are written on the cfg port (cfg_valid, cfg_ready always high,
//   cfg_index, cfg_data); bad indexes are ignored. The user must write them
//   only while no item is in flight; the block itself does not enforce it.
//   Reset clears all items in flight and loads the register defaults.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller import gtg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        pose_valid,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [HEAD_W-1:0]    heading,
    input  logic signed [POS_W-1:0]     target_x,
    input  logic signed [POS_W-1:0]     target_y,
    output logic                        done,
    output logic signed [15:0]          forward_velocity,
    output logic signed [15:0]          turn_rate,
    output logic                        at_goal,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [15:0]                 cfg_data
);

    localparam int PROD_W = 48;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FW_W   = SUM_W - CQ;
    localparam int SIDE_W = 18;
    localparam int TP_W   = 36;
    localparam int TF_W   = TP_W - FRAC_BITS;
    localparam int SPF_W  = 16 + DIST_W;

    localparam logic signed [SUM_W-1:0] CS_HALF   = SUM_W'(1) <<< (CQ - 1);
    localparam logic signed [TP_W-1:0]  TURN_HALF = TP_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [FW_W-1:0]  FW_MAX    = FW_W'(32767);
    localparam logic signed [FW_W-1:0]  FW_MIN    = -FW_W'(32768);

    // configuration registers
    logic [14:0] goal_tol_reg;
    logic [15:0] speed_gain_reg;
    logic [14:0] max_speed_reg;
    logic [14:0] max_turn_reg;
    logic [15:0] turn_gain_reg;
    logic [11:0] deadband_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_tol_reg   <= 15'd614;
            speed_gain_reg <= 16'd4096;
            max_speed_reg  <= 15'd901;
            max_turn_reg   <= 15'd11633;
            turn_gain_reg  <= 16'd8192;
            deadband_reg   <= 12'd41;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOL:      goal_tol_reg   <= cfg_data[14:0];
                CFG_SPD_GAIN: speed_gain_reg <= cfg_data;
                CFG_MAX_SPD:  max_speed_reg  <= cfg_data[14:0];
                CFG_MAX_TURN: max_turn_reg   <= cfg_data[14:0];
                CFG_TRN_GAIN: turn_gain_reg  <= cfg_data;
                CFG_DEADBAND: deadband_reg   <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // valid bits along the pipeline
    logic [ST_TURN:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[ST_TURN-1:1], start & ~busy};
    end

    // offsets and reduced heading at stage one
    logic signed [POS_W:0]   dx_w;
    logic signed [POS_W:0]   dy_w;
    logic signed [POS_W:0]   dx_abs;
    logic signed [POS_W:0]   dy_abs;
    logic signed [ANG_W-1:0] ang_raw;
    logic signed [ANG_W-1:0] ang_next;
    logic signed [ANG_W-1:0] ang_reg;

    always_comb
    begin
        dx_w    = (POS_W+1)'(target_x) - (POS_W+1)'(pos_x);
        dy_w    = (POS_W+1)'(target_y) - (POS_W+1)'(pos_y);
        dx_abs  = dx_w[POS_W] ? -dx_w : dx_w;
        dy_abs  = dy_w[POS_W] ? -dy_w : dy_w;
        ang_raw = {{(ANG_W-HEAD_W-(CQ-FRAC_BITS)){heading[HEAD_W-1]}}, heading,
                   {(CQ-FRAC_BITS){1'b0}}};
        ang_next = ang_raw;
        if (ang_raw > PI_Q30)
            ang_next = ang_raw - TWO_PI_Q30;
        else if (ang_raw < -PI_Q30)
            ang_next = ang_raw + TWO_PI_Q30;
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
    end

    // per-item flags carried through the stages
    meta_t meta_reg  [1:ST_TURN];
    meta_t meta_next [1:ST_TURN];

    // squared distance
    logic [D2_W-1:0] xm_w;
    logic [D2_W-1:0] ym_w;
    logic [D2_W-1:0] tol_w;
    logic [D2_W-1:0] d2_reg;

    assign xm_w  = D2_W'(meta_reg[1].xmag);
    assign ym_w  = D2_W'(meta_reg[1].ymag);
    assign tol_w = D2_W'(goal_tol_reg);

    always_ff @(posedge clk)
    begin
        d2_reg <= xm_w * xm_w + ym_w * ym_w;
    end

    // distance
    logic [DIST_W-1:0] dist_q;

    gtg_sqrt u_sqrt
    (
        .clk  (clk),
        .d2   (d2_reg),
        .root (dist_q)
    );

    always_comb
    begin
        meta_next[1].pv   = pose_valid;
        meta_next[1].ag   = 1'b0;
        meta_next[1].dz   = 1'b0;
        meta_next[1].xneg = dx_w[POS_W];
        meta_next[1].yneg = dy_w[POS_W];
        meta_next[1].xmag = dx_abs[MAG_W-1:0];
        meta_next[1].ymag = dy_abs[MAG_W-1:0];
        for (int k = 2; k <= ST_TURN; k++)
            meta_next[k] = meta_reg[k-1];
        meta_next[ST_AG].ag  = (d2_reg < tol_w * tol_w);
        meta_next[ST_SPD].dz = (dist_q == '0);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= ST_TURN; k++)
            meta_reg[k] <= meta_next[k];
    end

    // capped speed
    logic [SPF_W-1:0]       spd_full;
    logic [SPF_W-1:0]       gain_w;
    logic [SPD_W-1:0]       speed_reg;
    logic [DIST_W-1:0]      dist_reg;

    assign gain_w   = SPF_W'(speed_gain_reg);
    assign spd_full = gain_w * SPF_W'(dist_q);

    always_ff @(posedge clk)
    begin
        if (spd_full[SPF_W-1:FRAC_BITS] > (SPF_W-FRAC_BITS)'(max_speed_reg))
            speed_reg <= max_speed_reg;
        else
            speed_reg <= spd_full[FRAC_BITS +: SPD_W];
        dist_reg <= dist_q;
    end

    // rounding division operands
    logic [NUM_W-1:0] spd_w;
    logic [NUM_W-1:0] numx_reg;
    logic [NUM_W-1:0] numy_reg;
    logic [DEN_W-1:0] den_reg;

    assign spd_w = NUM_W'(speed_reg);

    always_ff @(posedge clk)
    begin
        numx_reg <= ((NUM_W'(meta_reg[ST_SPD].xmag) * spd_w) << 1) + NUM_W'(dist_reg);
        numy_reg <= ((NUM_W'(meta_reg[ST_SPD].ymag) * spd_w) << 1) + NUM_W'(dist_reg);
        den_reg  <= {dist_reg, 1'b0};
    end

    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;

    gtg_div u_div_x
    (
        .clk (clk),
        .num (numx_reg),
        .den (den_reg),
        .quo (qx)
    );

    gtg_div u_div_y
    (
        .clk (clk),
        .num (numy_reg),
        .den (den_reg),
        .quo (qy)
    );

    // signed world-frame velocity
    logic signed [QUO_W-1:0] vx_reg;
    logic signed [QUO_W-1:0] vy_reg;

    always_ff @(posedge clk)
    begin
        if (meta_reg[ST_Q].dz)
        begin
            vx_reg <= '0;
            vy_reg <= '0;
        end
        else
        begin
            vx_reg <= meta_reg[ST_Q].xneg ? -$signed(qx) : $signed(qx);
            vy_reg <= meta_reg[ST_Q].yneg ? -$signed(qy) : $signed(qy);
        end
    end

    // heading cosine and sine, delayed to meet the velocity
    logic signed [CS_W-1:0] cos_q;
    logic signed [CS_W-1:0] sin_q;
    logic signed [CS_W-1:0] c_dly_reg [CS_DLY];
    logic signed [CS_W-1:0] s_dly_reg [CS_DLY];

    gtg_cordic u_cordic
    (
        .clk   (clk),
        .ang   (ang_reg),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    always_ff @(posedge clk)
    begin
        c_dly_reg[0] <= cos_q;
        s_dly_reg[0] <= sin_q;
        for (int k = 1; k < CS_DLY; k++)
        begin
            c_dly_reg[k] <= c_dly_reg[k-1];
            s_dly_reg[k] <= s_dly_reg[k-1];
        end
    end

    // rotation products
    logic signed [PROD_W-1:0] p_xc_reg;
    logic signed [PROD_W-1:0] p_ys_reg;
    logic signed [PROD_W-1:0] p_yc_reg;
    logic signed [PROD_W-1:0] p_xs_reg;

    always_ff @(posedge clk)
    begin
        p_xc_reg <= PROD_W'(vx_reg) * PROD_W'(c_dly_reg[CS_DLY-1]);
        p_ys_reg <= PROD_W'(vy_reg) * PROD_W'(s_dly_reg[CS_DLY-1]);
        p_yc_reg <= PROD_W'(vy_reg) * PROD_W'(c_dly_reg[CS_DLY-1]);
        p_xs_reg <= PROD_W'(vx_reg) * PROD_W'(s_dly_reg[CS_DLY-1]);
    end

    // robot-frame components, rounded half up
    logic signed [SUM_W-1:0]  fsum;
    logic signed [SUM_W-1:0]  ssum;
    logic signed [FW_W-1:0]   fw;
    logic signed [15:0]       fwd_reg;
    logic signed [SIDE_W-1:0] side_reg;

    assign fsum = SUM_W'(p_xc_reg) + SUM_W'(p_ys_reg) + CS_HALF;
    assign ssum = SUM_W'(p_yc_reg) - SUM_W'(p_xs_reg) + CS_HALF;
    assign fw   = fsum[SUM_W-1:CQ];

    always_ff @(posedge clk)
    begin
        if (fw > FW_MAX)
            fwd_reg <= 16'sh7fff;
        else if (fw < FW_MIN)
            fwd_reg <= 16'sh8000;
        else
            fwd_reg <= fw[15:0];
        side_reg <= ssum[CQ +: SIDE_W];
    end

    // deadband test and turn gain
    logic signed [SIDE_W-1:0] side_abs;
    logic signed [TP_W-1:0]   tprod_reg;
    logic                     big_reg;
    logic signed [15:0]       fwd2_reg;

    assign side_abs = side_reg[SIDE_W-1] ? -side_reg : side_reg;

    always_ff @(posedge clk)
    begin
        big_reg   <= (side_abs > $signed({{(SIDE_W-12){1'b0}}, deadband_reg}));
        tprod_reg <= TP_W'($signed({1'b0, turn_gain_reg})) * TP_W'(side_reg) + TURN_HALF;
        fwd2_reg  <= fwd_reg;
    end

    // clamp and output registers
    logic signed [TF_W-1:0] turn_full;
    logic signed [TF_W-1:0] mt_pos;
    logic signed [15:0]     turn_val;
    logic                   cmd_ok;

    assign turn_full = tprod_reg[TP_W-1:FRAC_BITS];
    assign mt_pos    = $signed({{(TF_W-15){1'b0}}, max_turn_reg});
    assign cmd_ok    = meta_reg[ST_TURN].pv && !meta_reg[ST_TURN].ag;

    always_comb
    begin
        if (!big_reg)
            turn_val = '0;
        else if (turn_full > mt_pos)
            turn_val = mt_pos[15:0];
        else if (turn_full < -mt_pos)
            turn_val = -mt_pos[15:0];
        else
            turn_val = turn_full[15:0];
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[ST_TURN];
    end

    always_ff @(posedge clk)
    begin
        forward_velocity <= cmd_ok ? fwd2_reg : '0;
        turn_rate        <= cmd_ok ? turn_val : '0;
        at_goal          <= meta_reg[ST_TURN].pv && meta_reg[ST_TURN].ag;
    end

    assign done = done_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##ST_OUT done)
        else $error("result did not appear at fixed latency");

    a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && at_goal |-> forward_velocity == 0 && turn_rate == 0)
        else $error("nonzero command at goal");

    a_turn_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> turn_rate <= $signed({1'b0, max_turn_reg})
              && turn_rate >= -$signed({1'b0, max_turn_reg}))
        else $error("turn command beyond limit");

endmodule

// File: verif/go_to_goal_velocity_controller_checker.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_checker
// Watches the item, result and register channels of the go-to-goal
// controller, predicts each command from its own copy of the registers and
// compares every result field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_checker import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     pose_valid,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [HEAD_W-1:0] heading,
    input  logic signed [POS_W-1:0]  target_x,
    input  logic signed [POS_W-1:0]  target_y,
    input  logic                     done,
    input  logic signed [15:0]       forward_velocity,
    input  logic signed [15:0]       turn_rate,
    input  logic                     at_goal,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]              cfg_data,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] fwd;
        logic signed [15:0] turn;
        logic               reached;
    } command_t;

    command_t cmd_q [$];

    // shadow registers
    logic [14:0] tol_r;
    logic [15:0] spd_gain_r;
    logic [14:0] max_spd_r;
    logic [14:0] max_turn_r;
    logic [15:0] trn_gain_r;
    logic [11:0] deadband_r;

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 40;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // rounded component of the speed along one offset axis
    function automatic longint axis_speed(longint d, longint spd, longint dlen);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = (2 * mag * spd + dlen) / (2 * dlen);
        return (d < 0) ? -q : q;
    endfunction

    function automatic command_t predict_command(logic pv, logic signed [15:0] px,
        logic signed [15:0] py, logic signed [14:0] hd, logic signed [15:0] tx,
        logic signed [15:0] ty);
        command_t r;
        longint dx, dy, d2, dlen, spd, vx, vy;
        longint a, x, y, z, xs, ys, c, s, fwd, side, turn;
        longint tol;
        bit flip;
        r.fwd = '0;
        r.turn = '0;
        r.reached = 1'b0;
        if (!pv)
            return r;
        dx = longint'(tx) - longint'(px);
        dy = longint'(ty) - longint'(py);
        d2 = dx * dx + dy * dy;
        tol = longint'(tol_r);
        if (d2 < tol * tol)
        begin
            r.reached = 1'b1;
            return r;
        end
        dlen = int_sqrt(d2);
        spd = (longint'(spd_gain_r) * dlen) >>> FRAC_BITS;
        if (spd > longint'(max_spd_r))
            spd = longint'(max_spd_r);
        vx = 0;
        vy = 0;
        if (dlen != 0)
        begin
            vx = axis_speed(dx, spd, dlen);
            vy = axis_speed(dy, spd, dlen);
        end
        // heading into [-pi/2, pi/2] with a half-turn fold
        a = longint'(hd) * (longint'(1) << (CQ - FRAC_BITS));
        a = a % longint'(TWO_PI_Q30);
        if (a > longint'(PI_Q30))
            a = a - longint'(TWO_PI_Q30);
        if (a < -longint'(PI_Q30))
            a = a + longint'(TWO_PI_Q30);
        flip = 1'b0;
        if (a > longint'(HALF_PI_Q30))
        begin
            a = a - longint'(PI_Q30);
            flip = 1'b1;
        end
        else if (a < -longint'(HALF_PI_Q30))
        begin
            a = a + longint'(PI_Q30);
            flip = 1'b1;
        end
        // rotation-mode cordic
        x = longint'(GAIN_Q30);
        y = 0;
        z = a;
        for (int i = 0; i < CORDIC_ITER; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_Q30[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_Q30[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        fwd = (vx * c + vy * s + (longint'(1) << (CQ - 1))) >>> CQ;
        side = (vy * c - vx * s + (longint'(1) << (CQ - 1))) >>> CQ;
        if (fwd > 32767)
            fwd = 32767;
        if (fwd < -32768)
            fwd = -32768;
        turn = 0;
        if (((side < 0) ? -side : side) > longint'(deadband_r))
        begin
            turn = (longint'(trn_gain_r) * side + (longint'(1) << (FRAC_BITS - 1)))
                >>> FRAC_BITS;
            if (turn > longint'(max_turn_r))
                turn = longint'(max_turn_r);
            if (turn < -longint'(max_turn_r))
                turn = -longint'(max_turn_r);
        end
        r.fwd = 16'(fwd);
        r.turn = 16'(turn);
        return r;
    endfunction

    assign pending = cmd_q.size();

    // register writes, item predictions and result compare
    always @(posedge clk or negedge rst_n)
    begin
        command_t e;
        if (!rst_n)
        begin
            tol_r      <= 15'd614;
            spd_gain_r <= 16'd4096;
            max_spd_r  <= 15'd901;
            max_turn_r <= 15'd11633;
            trn_gain_r <= 16'd8192;
            deadband_r <= 12'd41;
            cmd_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TOL:      tol_r      <= cfg_data[14:0];
                    CFG_SPD_GAIN: spd_gain_r <= cfg_data;
                    CFG_MAX_SPD:  max_spd_r  <= cfg_data[14:0];
                    CFG_MAX_TURN: max_turn_r <= cfg_data[14:0];
                    CFG_TRN_GAIN: trn_gain_r <= cfg_data;
                    CFG_DEADBAND: deadband_r <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                cmd_q = {cmd_q, predict_command(pose_valid, pos_x, pos_y, heading,
                    target_x, target_y)};
            if (done)
            begin
                if (cmd_q.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = cmd_q.pop_front();
                    if (forward_velocity !== e.fwd || turn_rate !== e.turn ||
                        at_goal !== e.reached)
                        fail_count <= fail_count + 1;
                    if (forward_velocity !== e.fwd)
                        $error("forward_velocity expected %0d got %0d", e.fwd,
                            forward_velocity);
                    if (turn_rate !== e.turn)
                        $error("turn_rate expected %0d got %0d", e.turn, turn_rate);
                    if (at_goal !== e.reached)
                        $error("at_goal expected %0b got %0b", e.reached, at_goal);
                end
            end
        end
    end

endmodule

// File: verif/go_to_goal_velocity_controller_tb.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_tb
// Drives directed and random pose items through the controller under
// several register settings, with random gaps between items in some
// phases and none in others, and lets the checker score every result.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_tb import gtg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 3000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     pose_valid = 1'b0;
    logic signed [POS_W-1:0]  pos_x = '0;
    logic signed [POS_W-1:0]  pos_y = '0;
    logic signed [HEAD_W-1:0] heading = '0;
    logic signed [POS_W-1:0]  target_x = '0;
    logic signed [POS_W-1:0]  target_y = '0;
    logic                     done;
    logic signed [15:0]       forward_velocity;
    logic signed [15:0]       turn_rate;
    logic                     at_goal;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [15:0]              cfg_data = '0;
    int                       fail_count;
    int                       pending;
    int                       idle_cycles = 0;
    bit                       no_gaps = 1'b0;

    always #10 clk = ~clk;

    go_to_goal_velocity_controller i_dut (.*);

    go_to_goal_velocity_controller_checker i_checker (.*);

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL go_to_goal_velocity_controller");
            $finish;
        end
    end

    task automatic send_pose(logic pv, logic [15:0] px, logic [15:0] py,
        logic [14:0] hd, logic [15:0] tx, logic [15:0] ty);
        int gap;
        start      <= 1'b1;
        pose_valid <= pv;
        pos_x      <= px;
        pos_y      <= py;
        heading    <= hd;
        target_x   <= tx;
        target_y   <= ty;
        do
            @(posedge clk);
        while (busy);
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_pose();
        logic [15:0] px, py, tx, ty;
        logic [14:0] hd;
        int kind;
        px = 16'($urandom);
        py = 16'($urandom);
        hd = ($urandom_range(0, 9) < 7) ? 15'($signed($urandom_range(0, 25736)) - 12868)
                                        : 15'($urandom);
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            // near the goal: around the tolerance and deadband edges
            tx = px + 16'($signed($urandom_range(0, 2400)) - 1200);
            ty = py + 16'($signed($urandom_range(0, 2400)) - 1200);
        end
        else if (kind == 4)
        begin
            tx = px;
            ty = py;
        end
        else
        begin
            tx = 16'($urandom);
            ty = 16'($urandom);
        end
        send_pose($urandom_range(0, 9) != 0, px, py, hd, tx, ty);
    endtask

    // register batch, written only once the pipeline has drained
    task automatic program_regs(logic [15:0] tol, logic [15:0] sg, logic [15:0] ms,
        logic [15:0] mt, logic [15:0] tg, logic [15:0] db);
        logic [15:0] vals [6];
        vals = '{tol, sg, ms, mt, tg, db};
        if (start)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= (i < 6) ? vals[i] : 16'($urandom);
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: special cases under reset values
        send_pose(1'b0, 16'h1234, 16'h0100, 15'd0, 16'h7000, 16'h0000);
        send_pose(1'b1, 16'd0, 16'd0, 15'd0, 16'd100, 16'd100);
        send_pose(1'b1, 16'd500, 16'd500, 15'd0, 16'd500, 16'd500);
        send_pose(1'b1, 16'h8000, 16'h8000, 15'd0, 16'h7FFF, 16'h7FFF);
        send_pose(1'b1, 16'h7FFF, 16'h7FFF, 15'd12868, 16'h8000, 16'h8000);
        send_pose(1'b1, 16'd0, 16'd0, -15'sd12868, 16'd0, 16'h4000);
        send_pose(1'b1, 16'd0, 16'd0, 15'h3FFF, 16'h4000, 16'd0);
        send_pose(1'b1, 16'd0, 16'd0, 15'h4000, 16'h4000, 16'd0);
        send_pose(1'b1, 16'd0, 16'd0, 15'd6434, 16'h4000, 16'd0);
        send_pose(1'b1, 16'd0, 16'd0, -15'sd6434, 16'd0, 16'hC000);
        send_pose(1'b1, 16'd0, 16'd0, 15'd30, 16'd4096, 16'd0);
        send_pose(1'b1, 16'd0, 16'd0, 15'd0, 16'd4096, 16'd40);
        send_pose(1'b1, 16'd0, 16'd0, 15'd0, 16'd613, 16'd0);
        send_pose(1'b1, 16'd0, 16'd0, 15'd0, 16'd614, 16'd0);
        send_pose(1'b0, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF);

        // zero registers: zero tolerance and zero distance
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pose(1'b1, 16'd77, 16'd77, 15'd0, 16'd77, 16'd77);
        send_pose(1'b1, 16'd0, 16'd0, 15'd100, 16'd2000, 16'd3000);
        repeat (40) random_pose();

        // all registers at their maximum, written with junk upper bits
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (30) random_pose();
        program_regs(16'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd0);
        send_pose(1'b1, 16'h8000, 16'h8000, 15'd6434, 16'h7FFF, 16'h7FFF);
        send_pose(1'b1, 16'h7FFF, 16'h8000, -15'sd3217, 16'h8000, 16'h7FFF);
        repeat (60) random_pose();

        // random settings, some phases back to back
        for (int p = 0; p < 7; p++)
        begin
            program_regs(16'($urandom_range(0, 1500)), 16'($urandom),
                16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                16'($urandom), 16'($urandom_range(0, 4095)));
            no_gaps = (p % 3 == 0);
            repeat (85) random_pose();
        end
        no_gaps = 1'b0;

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS go_to_goal_velocity_controller");
        else
            $display("FAIL go_to_goal_velocity_controller");
        $finish;
    end

endmodule
